@@ hdl/vn4_pkg.sv @@
`timescale 1ns / 1ps
package vn4_pkg;

  localparam int unsigned CW    = 32;
  localparam int unsigned LW    = CW + 1;
  localparam int unsigned SQW   = 2 * CW;
  localparam int unsigned SUMW  = SQW + 1;
  localparam int unsigned RADW  = 2 * LW;
  localparam int unsigned REMW  = LW + 3;
  localparam int unsigned UF    = 30;
  localparam int unsigned QW    = UF + 1;
  localparam int unsigned DREMW = LW + 1;
  localparam int unsigned UW    = 32;
  localparam int unsigned LANES = 4;

  typedef struct packed {
    logic                       vld;
    logic [RADW-1:0]            rad;
    logic [REMW-1:0]            rem;
    logic [LW-1:0]              root;
    logic [LANES-1:0][CW-1:0]   mag;
    logic [LANES-1:0]           neg;
  } sq_t;

  typedef struct packed {
    logic                       vld;
    logic [LANES-1:0][DREMW-1:0] rem;
    logic [LANES-1:0][QW-1:0]   quo;
    logic [LW-1:0]              len;
    logic [LANES-1:0]           neg;
  } dv_t;

endpackage

@@ hdl/vn4_front.sv @@
`timescale 1ns / 1ps
module vn4_front (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     vld_i,
  input  logic [vn4_pkg::LANES-1:0][vn4_pkg::CW-1:0] comp_i,
  output vn4_pkg::sq_t                             sq_o
);
  import vn4_pkg::*;

  logic                     a_vld_q, b_vld_q, c_vld_q;
  logic [LANES-1:0][CW-1:0] a_mag_d, a_mag_q, b_mag_q, c_mag_q;
  logic [LANES-1:0]         a_neg_q, b_neg_q, c_neg_q;
  logic [LANES-1:0][SQW-1:0] b_sq_q;
  logic [SUMW-1:0]          c_sum_d, c_sum_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      a_mag_d[l] = comp_i[l][CW-1] ? (~comp_i[l] + 1'b1) : comp_i[l];
    end
    c_sum_d = ({1'b0, b_sq_q[0]} + {1'b0, b_sq_q[1]})
            + ({1'b0, b_sq_q[2]} + {1'b0, b_sq_q[3]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      a_vld_q <= vld_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_mag_q <= a_mag_d;
    for (int l = 0; l < LANES; l++) begin
      a_neg_q[l] <= comp_i[l][CW-1];
      b_sq_q[l]  <= SQW'(a_mag_q[l]) * SQW'(a_mag_q[l]);
    end
    b_mag_q <= a_mag_q;
    b_neg_q <= a_neg_q;
    c_mag_q <= b_mag_q;
    c_neg_q <= b_neg_q;
    c_sum_q <= c_sum_d;
  end

  always_comb begin
    sq_o.vld  = c_vld_q;
    sq_o.rad  = {{(RADW-SUMW){1'b0}}, c_sum_q};
    sq_o.rem  = '0;
    sq_o.root = '0;
    sq_o.mag  = c_mag_q;
    sq_o.neg  = c_neg_q;
  end

endmodule

@@ hdl/vn4_sqrt_cell.sv @@
`timescale 1ns / 1ps
module vn4_sqrt_cell (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  vn4_pkg::sq_t sq_i,
  output vn4_pkg::sq_t sq_o
);
  import vn4_pkg::*;

  sq_t             sq_d, sq_q;
  logic [REMW-1:0] r_sh, t;
  logic            ge;

  always_comb begin
    r_sh = {sq_i.rem[REMW-3:0], sq_i.rad[RADW-1:RADW-2]};
    t    = {{(REMW-LW-1){1'b0}}, sq_i.root[LW-2:0], 1'b0, 1'b1};
    ge   = r_sh >= t;
    sq_d      = sq_i;
    sq_d.rad  = {sq_i.rad[RADW-3:0], 2'b00};
    sq_d.rem  = ge ? (r_sh - t) : r_sh;
    sq_d.root = {sq_i.root[LW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q <= '0;
    end else begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

@@ hdl/vn4_div_cell.sv @@
`timescale 1ns / 1ps
module vn4_div_cell (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  vn4_pkg::dv_t dv_i,
  output vn4_pkg::dv_t dv_o
);
  import vn4_pkg::*;

  dv_t dv_d, dv_q;
  logic [LANES-1:0] ge;

  always_comb begin
    dv_d = dv_i;
    for (int l = 0; l < LANES; l++) begin
      ge[l]          = dv_i.rem[l] >= {1'b0, dv_i.len};
      dv_d.rem[l]    = ge[l] ? (dv_i.rem[l] - {1'b0, dv_i.len}) : dv_i.rem[l];
      dv_d.quo[l]    = {dv_i.quo[l][QW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else begin
      dv_q <= dv_d;
    end
  end

  assign dv_o = dv_q;

endmodule

@@ hdl/vector4_normalize_unit.sv @@
`timescale 1ns / 1ps
// Channel  | Handshake            | Ports
// input    | start & !busy        | comp_x_i, comp_y_i, comp_z_i, comp_w_i
// result   | result_valid_o pulse | unit_*_o, length_o, zero_length_o
//
// One transaction per cycle; busy is never raised.
// Pipeline: 3 front stages, 33 root cells, 31 divide cells, output register.
// The root and divide cell chains produce one result bit per cell.
// Reset clears all valid bits at once; the receiver cannot stall.
module vector4_normalize_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [vn4_pkg::CW-1:0] comp_x_i,
  input  logic signed [vn4_pkg::CW-1:0] comp_y_i,
  input  logic signed [vn4_pkg::CW-1:0] comp_z_i,
  input  logic signed [vn4_pkg::CW-1:0] comp_w_i,
  output logic                      result_valid_o,
  output logic signed [vn4_pkg::UW-1:0] unit_x_o,
  output logic signed [vn4_pkg::UW-1:0] unit_y_o,
  output logic signed [vn4_pkg::UW-1:0] unit_z_o,
  output logic signed [vn4_pkg::UW-1:0] unit_w_o,
  output logic        [vn4_pkg::LW-1:0] length_o,
  output logic                      zero_length_o
);
  import vn4_pkg::*;

  logic [LANES-1:0][CW-1:0] comp;
  sq_t sq [LW+1];
  dv_t dv_in [QW];
  dv_t dv_out [QW];
  logic                     vld_q;
  logic [LANES-1:0][UW-1:0] unit_d, unit_q;
  logic [LW-1:0]            len_q;
  logic                     zero_d, zero_q;

  assign busy = 1'b0;
  assign comp = {comp_w_i, comp_z_i, comp_y_i, comp_x_i};

  vn4_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start & ~busy),
    .comp_i (comp),
    .sq_o   (sq[0])
  );

  for (genvar i = 0; i < LW; i++) begin : g_sqrt
    vn4_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .sq_i   (sq[i]),
      .sq_o   (sq[i+1])
    );
  end

  always_comb begin
    dv_in[0].vld = sq[LW].vld;
    dv_in[0].len = sq[LW].root;
    dv_in[0].neg = sq[LW].neg;
    for (int l = 0; l < LANES; l++) begin
      dv_in[0].rem[l] = {{(DREMW-CW){1'b0}}, sq[LW].mag[l]};
      dv_in[0].quo[l] = '0;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    if (i > 0) begin : g_link
      always_comb begin
        dv_in[i] = dv_out[i-1];
        for (int l = 0; l < LANES; l++) begin
          dv_in[i].rem[l] = {dv_out[i-1].rem[l][DREMW-2:0], 1'b0};
        end
      end
    end
    vn4_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .dv_i   (dv_in[i]),
      .dv_o   (dv_out[i])
    );
  end

  always_comb begin
    zero_d = dv_out[QW-1].len == '0;
    for (int l = 0; l < LANES; l++) begin
      if (zero_d) begin
        unit_d[l] = '0;
      end else if (dv_out[QW-1].neg[l]) begin
        unit_d[l] = ~{{(UW-QW){1'b0}}, dv_out[QW-1].quo[l]} + 1'b1;
      end else begin
        unit_d[l] = {{(UW-QW){1'b0}}, dv_out[QW-1].quo[l]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= dv_out[QW-1].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q <= unit_d;
    len_q  <= dv_out[QW-1].len;
    zero_q <= zero_d;
  end

  assign result_valid_o = vld_q;
  assign unit_x_o       = unit_q[0];
  assign unit_y_o       = unit_q[1];
  assign unit_z_o       = unit_q[2];
  assign unit_w_o       = unit_q[3];
  assign length_o       = len_q;
  assign zero_length_o  = zero_q;

endmodule

@@ hdl/vn4_checker.sv @@
`timescale 1ns / 1ps
module vn4_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      busy,
  input logic                      result_valid_o,
  input logic [vn4_pkg::UW-1:0]    unit_x_o,
  input logic [vn4_pkg::UW-1:0]    unit_y_o,
  input logic [vn4_pkg::UW-1:0]    unit_z_o,
  input logic [vn4_pkg::UW-1:0]    unit_w_o,
  input logic [vn4_pkg::LW-1:0]    length_o,
  input logic                      zero_length_o
);
  import vn4_pkg::*;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && zero_length_o |->
      length_o == '0 && unit_x_o == '0 && unit_y_o == '0 && unit_z_o == '0
      && unit_w_o == '0)
    else $error("zero-length result not cleared");

  a_nonzero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !zero_length_o |-> length_o != '0)
    else $error("zero length without flag");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      ($signed(unit_x_o) <= $signed(UW'(1) << UF))
      && ($signed(unit_x_o) >= -$signed(UW'(1) << UF)))
    else $error("unit component out of range");

endmodule

bind vector4_normalize_unit vn4_checker u_vn4_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .unit_x_o       (unit_x_o),
  .unit_y_o       (unit_y_o),
  .unit_z_o       (unit_z_o),
  .unit_w_o       (unit_w_o),
  .length_o       (length_o),
  .zero_length_o  (zero_length_o)
);
